FILE: rtl/multicart_bank_mapper_top_macros.svh
// ----------------------------------------------------------------------------
// Multicart bank mapper assertion macros
// Clocked assertion wrappers used by the port checker.
// ----------------------------------------------------------------------------
`ifndef MULTICART_BANK_MAPPER_TOP_MACROS_SVH
`define MULTICART_BANK_MAPPER_TOP_MACROS_SVH

// Plain clocked assertion, active during reset too.
`define MCBM_ASSERT_CLK(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("mcbm assertion failed");

// Clocked assertion, switched off while reset is asserted.
`define MCBM_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("mcbm assertion failed");

`endif

FILE: rtl/mcbm_pkg.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper package
// Request codes, decode constants and the bank register file request type.
// ----------------------------------------------------------------------------
package mcbm_pkg;

  typedef enum logic [1:0] {
    FUNC_WRITE = 2'd0,
    FUNC_PRG   = 2'd1,
    FUNC_CHR   = 2'd2,
    FUNC_IDLE  = 2'd3
  } func_t;

  localparam int unsigned BANK_REGS = 8;
  localparam int unsigned BANK_AW   = $clog2(BANK_REGS);

  localparam logic [15:0] ADDR_DECODE    = 16'hE001;
  localparam logic [15:0] ADDR_BANK_SEL  = 16'h8000;
  localparam logic [15:0] ADDR_BANK_DATA = 16'h8001;

  localparam int unsigned SEL_PRG_SWAP_BIT = 6;
  localparam int unsigned SEL_CHR_INV_BIT  = 7;

  localparam logic [7:0] BANK_FIXED_LAST  = 8'hFF;
  localparam logic [7:0] BANK_FIXED_PENUL = 8'hFE;

  // Register numbers used by the lookups
  localparam logic [BANK_AW-1:0] REG_PRG_A = 3'd6;
  localparam logic [BANK_AW-1:0] REG_PRG_B = 3'd7;

  // Bank register contents after reset, R0..R7
  localparam logic [7:0] BANK_RESET [BANK_REGS] = '{
    8'd0, 8'd2, 8'd4, 8'd5, 8'd6, 8'd7, 8'd0, 8'd1
  };

  typedef struct packed {
    logic               we;
    logic [BANK_AW-1:0] waddr;
    logic [7:0]         wdata;
    logic               re;
    logic [BANK_AW-1:0] raddr;
  } ram_req_t;

endpackage

FILE: rtl/mcbm_in_if.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper request channel
// Valid/ready channel carrying one CPU or video bus request.
// ----------------------------------------------------------------------------
interface mcbm_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic [15:0] address;
  logic [7:0]  data;

  modport source (output valid, output func, output address, output data, input ready);
  modport sink   (input valid, input func, input address, input data, output ready);
endinterface

FILE: rtl/mcbm_out_if.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper result channel
// Valid/ready channel carrying one translated ROM offset.
// ----------------------------------------------------------------------------
interface mcbm_out_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [19:0] rom_offset;

  modport source (output valid, output hit, output rom_offset, input ready);
  modport sink   (input valid, input hit, input rom_offset, output ready);
endinterface

FILE: rtl/mcbm_bank_ram.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper bank register file
// Eight byte RAM, registered read, per-entry valid bits that make
// unwritten entries read as their reset contents.
// ----------------------------------------------------------------------------
module mcbm_bank_ram (
  input  logic                     clk,
  input  logic                     rst_n,
  input  mcbm_pkg::ram_req_t       req,
  output logic [7:0]               rdata
);

  logic [7:0]                    mem [mcbm_pkg::BANK_REGS];
  logic [mcbm_pkg::BANK_REGS-1:0] valid_r;
  logic [7:0]                    mem_q_r;
  logic                          vld_q_r;
  logic [mcbm_pkg::BANK_AW-1:0]  raddr_q_r;

  // Read before write: a read sees the contents from earlier edges only
  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      mem_q_r   <= mem[req.raddr];
      raddr_q_r <= req.raddr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      vld_q_r <= 1'b0;
    end else begin
      if (req.re) begin
        vld_q_r <= valid_r[req.raddr];
      end
      if (req.we) begin
        valid_r[req.waddr] <= 1'b1;
      end
    end
  end

  assign rdata = vld_q_r ? mem_q_r : mcbm_pkg::BANK_RESET[raddr_q_r];

endmodule

FILE: rtl/multicart_bank_mapper_top.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper top level
// Request to result: bank RAM read (stage 1), then the output register.
// One request per cycle while results drain; one bank RAM access per cycle.
// Reset (synchronous, rst_n low): pipeline empty, outer register unlocked,
// size masks at full ROM, bank registers at their power-on values at once.
// ----------------------------------------------------------------------------
module multicart_bank_mapper_top (
  input  logic        clk,
  input  logic        rst_n,
  mcbm_in_if.sink     in_ch,
  mcbm_out_if.source  out_ch,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic CFG_PRG_MASK = 1'b0;
  localparam logic CFG_CHR_MASK = 1'b1;

  typedef enum logic [1:0] {
    LK_NONE = 2'd0,
    LK_PRG  = 2'd1,
    LK_CHR  = 2'd2
  } lookup_t;

  typedef struct packed {
    lookup_t     kind;
    logic        use_mem;
    logic [7:0]  cval;
    logic        pair;
    logic        lsb;
    logic [12:0] low;
    logic [7:0]  outer;
  } stage_t;

  // Configuration and mapper control state
  logic [6:0] prg_mask_r;
  logic [9:0] chr_mask_r;
  logic [7:0] outer_latch_r;
  logic       outer_locked_r;
  logic [2:0] bank_sel_r;
  logic       prg_swap_r;
  logic       chr_inv_r;

  logic        s1_vld_r;
  stage_t      s1_r;
  stage_t      s1_nxt;
  logic        out_vld_r;
  logic        out_hit_r;
  logic [19:0] out_off_r;
  logic        out_hit_nxt;
  logic [19:0] out_off_nxt;

  logic                 acc;
  logic                 s1_adv;
  logic                 cfg_wr;
  mcbm_pkg::ram_req_t   ram_req;
  logic [7:0]           ram_rdata;
  logic [15:0]          dec_addr;
  logic                 wr_sel;
  logic                 wr_bank;
  logic                 wr_outer;
  logic [1:0]           pslot;
  logic [2:0]           cslot;

  // Output stage math
  logic [7:0]  bank_v;
  logic [6:0]  prg_outer;
  logic [4:0]  prg_inner;
  logic [6:0]  prg_bank;
  logic [9:0]  chr_outer;
  logic [7:0]  chr_inner;
  logic [9:0]  chr_bank;

  assign s1_adv       = s1_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready  = !s1_vld_r || s1_adv;
  assign acc          = in_ch.valid && in_ch.ready;
  assign cfg_pready   = 1'b1;
  assign cfg_wr       = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    case (cfg_paddr[2])
      CFG_PRG_MASK: cfg_prdata = {25'd0, prg_mask_r};
      default:      cfg_prdata = {22'd0, chr_mask_r};
    endcase
  end

  // Request decode
  always_comb begin
    dec_addr = in_ch.address & mcbm_pkg::ADDR_DECODE;
    wr_sel   = 1'b0;
    wr_bank  = 1'b0;
    wr_outer = 1'b0;
    pslot    = in_ch.address[14:13];
    cslot    = in_ch.address[12:10] ^ {chr_inv_r, 2'b00};

    ram_req       = '0;
    ram_req.waddr = bank_sel_r;
    ram_req.wdata = in_ch.data;

    s1_nxt         = '0;
    s1_nxt.kind    = LK_NONE;
    s1_nxt.low     = in_ch.address[12:0];
    s1_nxt.outer   = outer_latch_r;
    s1_nxt.lsb     = cslot[0];

    case (mcbm_pkg::func_t'(in_ch.func))
      mcbm_pkg::FUNC_WRITE: begin
        if (in_ch.address[15]) begin
          wr_sel  = (dec_addr == mcbm_pkg::ADDR_BANK_SEL);
          wr_bank = (dec_addr == mcbm_pkg::ADDR_BANK_DATA);
        end else begin
          wr_outer = (in_ch.address[14:13] == 2'b11) && !outer_locked_r;
        end
      end
      mcbm_pkg::FUNC_PRG: begin
        if (in_ch.address[15]) begin
          s1_nxt.kind = LK_PRG;
          if (pslot == 2'd1) begin
            s1_nxt.use_mem = 1'b1;
            ram_req.raddr  = mcbm_pkg::REG_PRG_B;
          end else if (pslot == 2'd3) begin
            s1_nxt.cval = mcbm_pkg::BANK_FIXED_LAST;
          end else if ((pslot == 2'd0) == !prg_swap_r) begin
            s1_nxt.use_mem = 1'b1;
            ram_req.raddr  = mcbm_pkg::REG_PRG_A;
          end else begin
            s1_nxt.cval = mcbm_pkg::BANK_FIXED_PENUL;
          end
        end
      end
      mcbm_pkg::FUNC_CHR: begin
        if (in_ch.address[15:13] == 3'd0) begin
          s1_nxt.kind    = LK_CHR;
          s1_nxt.use_mem = 1'b1;
          if (!cslot[2]) begin
            // 2K slots: R0 or R1 with its low bit taken from the slot
            s1_nxt.pair   = 1'b1;
            ram_req.raddr = {2'b00, cslot[1]};
          end else begin
            ram_req.raddr = cslot - 3'd2;
          end
        end
      end
      default: begin
      end
    endcase

    ram_req.we = acc && wr_bank;
    ram_req.re = acc && s1_nxt.use_mem;
  end

  mcbm_bank_ram u_bank_ram (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ram_req),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prg_mask_r     <= 7'd127;
      chr_mask_r     <= 10'd1023;
      outer_latch_r  <= '0;
      outer_locked_r <= 1'b0;
      bank_sel_r     <= '0;
      prg_swap_r     <= 1'b0;
      chr_inv_r      <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_paddr[2])
          CFG_PRG_MASK: prg_mask_r <= cfg_pwdata[6:0];
          default:      chr_mask_r <= cfg_pwdata[9:0];
        endcase
      end
      if (acc && wr_sel) begin
        bank_sel_r <= in_ch.data[2:0];
        prg_swap_r <= in_ch.data[mcbm_pkg::SEL_PRG_SWAP_BIT];
        chr_inv_r  <= in_ch.data[mcbm_pkg::SEL_CHR_INV_BIT];
      end
      if (acc && wr_outer) begin
        outer_latch_r  <= in_ch.data;
        outer_locked_r <= 1'b1;
      end
    end
  end

  // Stage 1: snapshot of the request alongside the RAM read
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (acc) begin
      s1_vld_r <= 1'b1;
    end else if (s1_adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      s1_r <= s1_nxt;
    end
  end

  // Bank number and ROM offset from the outer block and size masks
  always_comb begin
    if (!s1_r.use_mem) begin
      bank_v = s1_r.cval;
    end else if (s1_r.pair) begin
      bank_v = {ram_rdata[7:1], s1_r.lsb};
    end else begin
      bank_v = ram_rdata;
    end

    prg_outer = {s1_r.outer[2:1], s1_r.outer[3] & s1_r.outer[0], 4'd0};
    prg_inner = s1_r.outer[3] ? 5'h0F : 5'h1F;
    prg_bank  = (prg_outer | {2'd0, bank_v[4:0] & prg_inner}) & prg_mask_r;

    chr_outer = {s1_r.outer[5], s1_r.outer[2], s1_r.outer[6] & s1_r.outer[4], 7'd0};
    chr_inner = s1_r.outer[6] ? 8'h7F : 8'hFF;
    chr_bank  = (chr_outer | {2'd0, bank_v & chr_inner}) & chr_mask_r;

    case (s1_r.kind)
      LK_PRG: begin
        out_hit_nxt = 1'b1;
        out_off_nxt = {prg_bank, s1_r.low};
      end
      LK_CHR: begin
        out_hit_nxt = 1'b1;
        out_off_nxt = {chr_bank, s1_r.low[9:0]};
      end
      default: begin
        out_hit_nxt = 1'b0;
        out_off_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (s1_adv) begin
      out_vld_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_hit_r <= out_hit_nxt;
      out_off_r <= out_off_nxt;
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.hit        = out_hit_r;
  assign out_ch.rom_offset = out_off_r;

endmodule

FILE: rtl/mcbm_checker.sv
// ----------------------------------------------------------------------------
// Multicart bank mapper port checker
// Watches the top level ports for result channel and backpressure behavior.
// ----------------------------------------------------------------------------
`include "multicart_bank_mapper_top_macros.svh"

module mcbm_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_hit,
  input logic [19:0] out_rom_offset
);

  logic [20:0] out_word;

  assign out_word = {out_hit, out_rom_offset};

  // Stalled result stays up and unchanged
  `MCBM_ASSERT_RST(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `MCBM_ASSERT_RST(a_out_stable, clk, rst_n, out_valid && !out_ready |=> $stable(out_word))

  // A miss always carries a zero offset
  `MCBM_ASSERT_RST(a_miss_zero, clk, rst_n, out_valid && !out_hit |-> out_rom_offset == 20'd0)

  // Requests are refused only when both stages are full and the sink stalls
  `MCBM_ASSERT_RST(a_ready_bp, clk, rst_n, !in_ready |-> out_valid && !out_ready)

  // Reset empties the result stage
  `MCBM_ASSERT_CLK(a_reset_empty, clk, !rst_n |=> !out_valid)

endmodule

bind multicart_bank_mapper_top mcbm_checker u_mcbm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ch.ready),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_hit        (out_ch.hit),
  .out_rom_offset (out_ch.rom_offset)
);
